// ----- hdl/fmwq_pkg.sv -----
// ----------------------------------------------------------------------------
// fmwq_pkg
// Shared types and constants of the fit-matching wait queue: request codes,
// result status codes, the queued command word and the engine states.
// ----------------------------------------------------------------------------
`default_nettype none

package fmwq_pkg;

  // Default queue depth
  localparam int unsigned FMWQ_DEPTH_DEF = 16;

  // Field widths
  localparam int unsigned KEY_W    = 64;
  localparam int unsigned SIZE_W   = 8;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned ENTRY_W  = KEY_W + SIZE_W;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DUP      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOFIT    = 3'd4;
  localparam logic [STATUS_W-1:0] ST_ENTRY    = 3'd5;

  // Request kinds after decode
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_ASSIGN = 2'd1,
    OP_LIST   = 2'd2,
    OP_SHOW   = 2'd3
  } op_t;

  // One decoded request, as it waits in the command queue
  typedef struct packed {
    op_t               op;
    logic [KEY_W-1:0]  key;
    logic [SIZE_W-1:0] size;
    logic [SIZE_W-1:0] cap;
  } cmd_t;

  // Engine states
  typedef enum logic [1:0] {
    ENG_IDLE  = 2'd0,
    ENG_SCAN  = 2'd1,
    ENG_FIN   = 2'd2,
    ENG_SHIFT = 2'd3
  } eng_state_t;

endpackage

`default_nettype wire

// ----- hdl/fit_matching_wait_queue.sv -----
// ----------------------------------------------------------------------------
// fit_matching_wait_queue
// Ordered wait queue of keyed, sized requests with insert, oldest-fit or
// best-fit assign, list and show. A front stage decodes requests into a
// two-deep command queue; the engine executes them against an entry RAM.
// ----------------------------------------------------------------------------
// Operation: a request scans its N queued entries (one RAM read per entry,
//   pipelined); after an assign removes position P, each later entry moves
//   down by one to close the gap. Full and empty cases skip the scan.
// Throughput: one request at a time in the engine; the command queue takes
//   up to two more while it works. Results leave at one per cycle at best.
// Reset: synchronous, active low; empties the queue and sets oldest-fit mode.
//   No clearing pass; entries are read only below the fill count.
`default_nettype none

module fit_matching_wait_queue
  import fmwq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = FMWQ_DEPTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic                cfg_fit_mode,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [1:0]          in_req_type,
  input  wire logic [KEY_W-1:0]    in_party_key,
  input  wire logic [SIZE_W-1:0]   in_party_size,
  input  wire logic [SIZE_W-1:0]   in_capacity,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [STATUS_W-1:0]      out_status,
  output logic [KEY_W-1:0]         out_key,
  output logic [SIZE_W-1:0]        out_size,
  output logic                     out_last
);

  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  logic          fit_mode_r;
  logic          cmd_valid;
  cmd_t          cmd;
  logic          cmd_pop;
  logic [CW-1:0] q_count;

  // Mode register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fit_mode_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      fit_mode_r <= cfg_fit_mode;
    end
  end

  fmwq_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_req_type   (in_req_type),
    .in_party_key  (in_party_key),
    .in_party_size (in_party_size),
    .in_capacity   (in_capacity),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .cmd_pop       (cmd_pop)
  );

  fmwq_engine #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .fit_mode   (fit_mode_r),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_pop    (cmd_pop),
    .q_count    (q_count),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_status (out_status),
    .out_key    (out_key),
    .out_size   (out_size),
    .out_last   (out_last)
  );

  // Fill count never passes the depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, q_count} <= (CW+1)'(QUEUE_DEPTH))
    else $error("queue count above depth");

  // Fill count moves by at most one per cycle
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, q_count} == {1'b0, $past(q_count)}) ||
    ({1'b0, q_count} == {1'b0, $past(q_count)} + (CW+1)'(1)) ||
    ({1'b0, q_count} + (CW+1)'(1) == {1'b0, $past(q_count)}))
    else $error("queue count jumped");

  // Only entry reports continue a run
  a_run_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> (out_status == ST_ENTRY))
    else $error("non-final result is not an entry report");

  // Result status stays within defined codes
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status <= ST_ENTRY))
    else $error("undefined result status");

endmodule

`default_nettype wire

// ----- hdl/fmwq_ram.sv -----
// ----------------------------------------------------------------------------
// fmwq_ram
// Generic single-write, single-read RAM with registered read data. Read data
// holds while no read is issued.
// ----------------------------------------------------------------------------
`default_nettype none

module fmwq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                      clk,
  input  wire logic                                      wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                          wr_data,
  input  wire logic                                      rd_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                          rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ----- hdl/fmwq_front.sv -----
// ----------------------------------------------------------------------------
// fmwq_front
// Input side: accept request beats, decode the request kind and hold up to
// two decoded commands for the engine.
// ----------------------------------------------------------------------------
`default_nettype none

module fmwq_front
  import fmwq_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [1:0]        in_req_type,
  input  wire logic [KEY_W-1:0]  in_party_key,
  input  wire logic [SIZE_W-1:0] in_party_size,
  input  wire logic [SIZE_W-1:0] in_capacity,
  output logic                   cmd_valid,
  output cmd_t                   cmd,
  input  wire logic              cmd_pop
);

  cmd_t       q_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] fill_r;
  cmd_t       dec;
  logic       push;
  logic       pop;

  // Decode the request kind
  always_comb begin
    dec.key  = in_party_key;
    dec.size = in_party_size;
    dec.cap  = in_capacity;
    unique case (in_req_type)
      2'd0:    dec.op = OP_INSERT;
      2'd1:    dec.op = OP_ASSIGN;
      2'd2:    dec.op = OP_LIST;
      default: dec.op = OP_SHOW;
    endcase
  end

  assign in_ready  = (fill_r != 2'd2);
  assign push      = in_valid && in_ready;
  assign cmd_valid = (fill_r != 2'd0);
  assign pop       = cmd_pop && cmd_valid;
  assign cmd       = q_r[rp_r];

  // Store the command
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= dec;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= 1'b0;
      rp_r   <= 1'b0;
      fill_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      if (push && !pop) begin
        fill_r <= fill_r + 2'd1;
      end else if (pop && !push) begin
        fill_r <= fill_r - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- hdl/fmwq_engine.sv -----
// ----------------------------------------------------------------------------
// fmwq_engine
// Back side: run one command at a time against the entry RAM. Scan entries
// with a pipelined read, report or pick entries, append on insert, close up
// the gap after a removal, and drive the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module fmwq_engine
  import fmwq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = FMWQ_DEPTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              fit_mode,
  input  wire logic                              cmd_valid,
  input  wire cmd_t                              cmd,
  output logic                                   cmd_pop,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]       q_count,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [STATUS_W-1:0]                    out_status,
  output logic [KEY_W-1:0]                       out_key,
  output logic [SIZE_W-1:0]                      out_size,
  output logic                                   out_last
);

  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
  localparam logic [CW-1:0] ONE_C   = CW'(1);

  eng_state_t state_r, state_nxt;

  cmd_t              cmd_r;
  logic [CW-1:0]     cnt_r;
  logic [CW-1:0]     iss_r;
  logic              rdv_r;
  logic [CW-1:0]     rpos_r;
  logic              dup_r;
  logic              found_r;
  logic [KEY_W-1:0]  best_key_r;
  logic [SIZE_W-1:0] best_size_r;
  logic [CW-1:0]     best_pos_r;
  logic              pend_v_r;
  logic [KEY_W-1:0]  pend_key_r;
  logic [SIZE_W-1:0] pend_size_r;

  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [KEY_W-1:0]    out_key_r;
  logic [SIZE_W-1:0]   out_size_r;
  logic                out_last_r;

  logic [ENTRY_W-1:0] rd_data;
  logic [KEY_W-1:0]   rd_key;
  logic [SIZE_W-1:0]  rd_size;
  logic               rd_en;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [ENTRY_W-1:0] wr_data;
  logic [CW-1:0]      shift_dst;

  logic                out_free;
  logic                fits;
  logic                scan_sel;
  logic                hold;
  logic                proc;
  logic                scan_done;
  logic                shift_done;
  logic                cmd_full;
  logic                cmd_empty;
  logic                cur_full;
  logic                cur_empty;
  logic                emit_en;
  logic [STATUS_W-1:0] emit_status;
  logic [KEY_W-1:0]    emit_key;
  logic [SIZE_W-1:0]   emit_size;
  logic                emit_last;
  logic                ins_commit;

  // Entry storage: key over size
  fmwq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (iss_r[AW-1:0]),
    .rd_data (rd_data)
  );

  assign rd_key    = rd_data[ENTRY_W-1:SIZE_W];
  assign rd_size   = rd_data[SIZE_W-1:0];
  assign shift_dst = rpos_r - ONE_C;

  // Entry classification
  assign out_free  = !out_valid_r || out_ready;
  assign fits      = (rd_size <= cmd_r.cap);
  assign scan_sel  = (cmd_r.op == OP_LIST) || ((cmd_r.op == OP_SHOW) && fits);
  assign cmd_full  = (cmd.op == OP_INSERT) && (cnt_r == DEPTH_C);
  assign cmd_empty = (cmd.op != OP_INSERT) && (cnt_r == '0);
  assign cur_full  = (cmd_r.op == OP_INSERT) && (cnt_r == DEPTH_C);
  assign cur_empty = (cmd_r.op != OP_INSERT) && (cnt_r == '0);

  // Scan pipeline control: stall while a held report cannot leave
  assign hold = (state_r == ENG_SCAN) && rdv_r && scan_sel && pend_v_r && !out_free;
  assign proc = (state_r == ENG_SCAN) && rdv_r && !hold;
  assign rd_en = ((state_r == ENG_SCAN) || (state_r == ENG_SHIFT)) &&
                 (iss_r < cnt_r) && !hold;
  assign scan_done  = (state_r == ENG_SCAN) && !rdv_r && (iss_r == cnt_r);
  assign shift_done = (state_r == ENG_SHIFT) && !rdv_r && (iss_r == cnt_r);
  assign cmd_pop    = (state_r == ENG_IDLE) && cmd_valid;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ENG_IDLE: begin
        if (cmd_valid) begin
          state_nxt = (cmd_full || cmd_empty) ? ENG_FIN : ENG_SCAN;
        end
      end
      ENG_SCAN: begin
        if (scan_done) begin
          state_nxt = ENG_FIN;
        end
      end
      ENG_FIN: begin
        if (out_free) begin
          state_nxt = (cmd_r.op == OP_ASSIGN && !cur_empty && found_r) ? ENG_SHIFT
                                                                       : ENG_IDLE;
        end
      end
      ENG_SHIFT: begin
        if (shift_done) begin
          state_nxt = ENG_IDLE;
        end
      end
      default: state_nxt = ENG_IDLE;
    endcase
  end

  // Outputs per state: results and RAM writes
  always_comb begin
    emit_en     = 1'b0;
    emit_status = ST_ENTRY;
    emit_key    = pend_key_r;
    emit_size   = pend_size_r;
    emit_last   = 1'b1;
    ins_commit  = 1'b0;
    wr_en       = 1'b0;
    wr_addr     = shift_dst[AW-1:0];
    wr_data     = rd_data;
    unique case (state_r)
      ENG_SCAN: begin
        // Release the previous report once a later one is known
        if (proc && scan_sel && pend_v_r) begin
          emit_en   = 1'b1;
          emit_last = 1'b0;
        end
      end
      ENG_FIN: begin
        emit_en = out_free;
        if (cmd_r.op == OP_INSERT) begin
          emit_key  = cmd_r.key;
          emit_size = cmd_r.size;
          if (cur_full) begin
            emit_status = ST_FULL;
          end else if (dup_r) begin
            emit_status = ST_DUP;
          end else begin
            emit_status = ST_INSERTED;
            ins_commit  = out_free;
            wr_en       = out_free;
            wr_addr     = cnt_r[AW-1:0];
            wr_data     = {cmd_r.key, cmd_r.size};
          end
        end else if (cur_empty) begin
          emit_status = ST_EMPTY;
          emit_key    = '0;
          emit_size   = '0;
        end else if (cmd_r.op == OP_ASSIGN) begin
          if (found_r) begin
            emit_key  = best_key_r;
            emit_size = best_size_r;
          end else begin
            emit_status = ST_NOFIT;
            emit_key    = '0;
            emit_size   = '0;
          end
        end else if (!pend_v_r) begin
          emit_status = ST_NOFIT;
          emit_key    = '0;
          emit_size   = '0;
        end
      end
      ENG_SHIFT: begin
        // Move each later entry down by one
        wr_en = rdv_r;
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ENG_IDLE;
      cnt_r   <= '0;
      rdv_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (!hold) begin
        rdv_r <= rd_en;
      end
      if (ins_commit) begin
        cnt_r <= cnt_r + ONE_C;
      end else if (shift_done) begin
        cnt_r <= cnt_r - ONE_C;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cmd_r    <= cmd;
      iss_r    <= '0;
      dup_r    <= 1'b0;
      found_r  <= 1'b0;
      pend_v_r <= 1'b0;
    end else begin
      if (rd_en) begin
        iss_r  <= iss_r + ONE_C;
        rpos_r <= iss_r;
      end
      if (state_r == ENG_FIN && out_free && cmd_r.op == OP_ASSIGN) begin
        iss_r <= best_pos_r + ONE_C;
      end
      if (proc) begin
        unique case (cmd_r.op)
          OP_INSERT: begin
            if (rd_key == cmd_r.key) begin
              dup_r <= 1'b1;
            end
          end
          OP_ASSIGN: begin
            if (fits && (!found_r || (fit_mode && rd_size > best_size_r))) begin
              found_r     <= 1'b1;
              best_key_r  <= rd_key;
              best_size_r <= rd_size;
              best_pos_r  <= rpos_r;
            end
          end
          default: begin
            if (scan_sel) begin
              pend_v_r    <= 1'b1;
              pend_key_r  <= rd_key;
              pend_size_r <= rd_size;
            end
          end
        endcase
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_en) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_en) begin
      out_status_r <= emit_status;
      out_key_r    <= emit_key;
      out_size_r   <= emit_size;
      out_last_r   <= emit_last;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_key    = out_key_r;
  assign out_size   = out_size_r;
  assign out_last   = out_last_r;
  assign q_count    = cnt_r;

endmodule

`default_nettype wire
